/* hdl/mdc_pkg.sv */
// shared types, codes and constants for the metaball dot coverage block
package mdc_pkg;

  // input item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_THR_LOW  = 3'd0;
  localparam logic [2:0] CFG_THR_HIGH = 3'd1;
  localparam logic [2:0] CFG_EPSILON  = 3'd2;
  localparam logic [2:0] CFG_MIN_DOT  = 3'd3;
  localparam logic [2:0] CFG_PITCH    = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [15:0] THR_LOW_RST  = 16'd2540;
  localparam logic [15:0] THR_HIGH_RST = 16'd4342;
  localparam logic [19:0] EPSILON_RST  = 20'd15099;
  localparam logic [11:0] MIN_DOT_RST  = 12'd512;
  localparam logic [11:0] PITCH_RST    = 12'd2560;

  // arithmetic constants
  localparam logic [23:0] FIELD_MAX = 24'hFFFFFF;
  localparam logic [12:0] COV_ONE   = 13'd4096;
  localparam logic [13:0] SS_K      = 14'd12288;

  // divider widths: dividend is radius_sq << 12, divisor the squared distance sum plus epsilon
  localparam int DIV_QW = 36;
  localparam int DIV_DW = 34;

  // shared multiplier operand widths
  localparam int MUL_AW = 25;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic               op;
    logic [2:0]         blob_index;
    logic signed [15:0] blob_x;
    logic signed [15:0] blob_y;
    logic [23:0]        blob_radius_sq;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
  } in_item_t;

  typedef struct packed {
    logic        covered;
    logic [11:0] dot_size;
    logic [11:0] dot_offset;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0]        r2;
  } blob_t;

  typedef struct packed {
    logic              start;
    logic [DIV_QW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_DSUM,
    S_DIVW,
    S_CMP,
    S_COVDIV,
    S_SS1,
    S_SS2,
    S_SS3,
    S_OUT
  } state_t;

endpackage

/* hdl/metaball_dot_coverage.sv */
// metaball field threshold: blob table, sequencer, shared multiplier and divider
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | in_valid / in_ready    | in_data  (mdc_pkg::in_item_t)
//  result   | out_valid / out_ready  | out_data (mdc_pkg::out_item_t)
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
// a load item writes the blob table when accepted. an evaluate item steps each
// blob with a nonzero radius through S_SQX, S_SQY, S_DSUM and S_DIVW (an empty
// blob is skipped in S_SQX), then the threshold compare, coverage ratio,
// smoothstep and output. the 36-step restoring divider is shared by every term
// and the coverage ratio. reset is synchronous and clears the blob table. a finished
// result waits in the output register without blocking the next item; only a
// second result waits for out_ready.
module metaball_dot_coverage #(
  parameter int NUM_BLOBS = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mdc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mdc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mdc_pkg::*;

  localparam int IDX_W = (NUM_BLOBS > 1) ? $clog2(NUM_BLOBS) : 1;

  state_t state_r, state_nxt;

  logic [15:0] thr_low_r, thr_high_r;
  logic [19:0] eps_r;
  logic [11:0] min_dot_r, pitch_r;

  blob_t             tbl_r [NUM_BLOBS];
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic signed [15:0] cx_r, cy_r;
  logic [31:0]       sq_r, sq_nxt;
  logic [23:0]       field_r, field_nxt;
  logic [12:0]       cov_r, cov_nxt;
  logic              covflag_r, covflag_nxt;
  logic [MUL_PW-1:0] mul_p_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              mul_en;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_QW-1:0] div_quot;

  blob_t             cur;
  logic              last;
  logic signed [16:0] dx, dy;
  logic [16:0]       ax, ay;
  logic [23:0]       term;
  logic [24:0]       fsum;
  logic              pitch_ge;
  logic [11:0]       pitch_diff;
  logic [11:0]       step;
  logic [11:0]       size;
  logic [11:0]       offset;
  logic              load_acc;

  mdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cur  = tbl_r[cnt_r];
  assign last = (cnt_r == IDX_W'(NUM_BLOBS - 1));

  always_comb begin
    dx = {cx_r[15], cx_r} - {cur.x[15], cur.x};
    dy = {cy_r[15], cy_r} - {cur.y[15], cur.y};
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    term = (div_quot > DIV_QW'(FIELD_MAX)) ? FIELD_MAX : div_quot[23:0];
    fsum = {1'b0, field_r} + {1'b0, term};
    pitch_ge   = (pitch_r >= min_dot_r);
    pitch_diff = pitch_ge ? (pitch_r - min_dot_r) : (min_dot_r - pitch_r);
    // s <= 1.0, so the scaled step never exceeds the pitch difference
    step   = mul_p_r[23:12];
    size   = pitch_ge ? (min_dot_r + step) : (min_dot_r - step);
    offset = (size > pitch_r) ? 12'd0 : 12'((pitch_r - size) >> 1);
  end

  assign load_acc = in_valid && in_ready && (in_data.op == OP_LOAD);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    field_nxt     = field_r;
    cov_nxt       = cov_r;
    covflag_nxt   = covflag_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.op == OP_EVAL) begin
          cnt_nxt   = '0;
          field_nxt = '0;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        // a blob with zero radius adds nothing
        if (cur.r2 == 24'd0) begin
          if (last) begin
            state_nxt = S_CMP;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          mul_en    = 1'b1;
          mul_a     = MUL_AW'(ax);
          mul_b     = ax;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        sq_nxt    = mul_p_r[31:0];
        mul_en    = 1'b1;
        mul_a     = MUL_AW'(ay);
        mul_b     = ay;
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {cur.r2, 12'd0};
        div_req.divisor  = DIV_DW'(sq_r) + DIV_DW'(mul_p_r[31:0]) + DIV_DW'(eps_r);
        state_nxt        = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          field_nxt = fsum[24] ? FIELD_MAX : fsum[23:0];
          if (last) begin
            state_nxt = S_CMP;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_SQX;
          end
        end
      end
      S_CMP: begin
        if (field_r <= 24'(thr_low_r)) begin
          covflag_nxt = 1'b0;
          state_nxt   = S_OUT;
        end else begin
          covflag_nxt = 1'b1;
          if (field_r >= 24'(thr_high_r)) begin
            cov_nxt   = COV_ONE;
            state_nxt = S_SS1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {field_r - 24'(thr_low_r), 12'd0};
            div_req.divisor  = DIV_DW'(thr_high_r - thr_low_r);
            state_nxt        = S_COVDIV;
          end
        end
      end
      S_COVDIV: begin
        if (div_done) begin
          cov_nxt   = div_quot[12:0];
          state_nxt = S_SS1;
        end
      end
      S_SS1: begin
        mul_en    = 1'b1;
        mul_a     = MUL_AW'(cov_r);
        mul_b     = MUL_BW'(cov_r);
        state_nxt = S_SS2;
      end
      S_SS2: begin
        // c*c * (3 - 2c) in Q.12
        mul_en    = 1'b1;
        mul_a     = mul_p_r[MUL_AW-1:0];
        mul_b     = MUL_BW'(SS_K - {cov_r, 1'b0});
        state_nxt = S_SS3;
      end
      S_SS3: begin
        mul_en    = 1'b1;
        mul_a     = MUL_AW'(mul_p_r[36:24]);
        mul_b     = MUL_BW'(pitch_diff);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = covflag_r ?
                          out_item_t'{covered: 1'b1, dot_size: size, dot_offset: offset} :
                          out_item_t'('0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    sq_r       <= sq_nxt;
    field_r    <= field_nxt;
    cov_r      <= cov_nxt;
    covflag_r  <= covflag_nxt;
    out_data_r <= out_data_nxt;
    if (mul_en) begin
      mul_p_r <= MUL_PW'(mul_a) * MUL_PW'(mul_b);
    end
    if (in_valid && in_ready && in_data.op == OP_EVAL) begin
      cx_r <= in_data.cell_x;
      cy_r <= in_data.cell_y;
    end
  end

  // blob table, cleared by reset so empty entries contribute nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= '{default: '0};
    end else if (load_acc && (int'(in_data.blob_index) < NUM_BLOBS)) begin
      tbl_r[IDX_W'(in_data.blob_index)] <= '{x: in_data.blob_x, y: in_data.blob_y,
                                              r2: in_data.blob_radius_sq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r  <= THR_LOW_RST;
      thr_high_r <= THR_HIGH_RST;
      eps_r      <= EPSILON_RST;
      min_dot_r  <= MIN_DOT_RST;
      pitch_r    <= PITCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THR_LOW:  thr_low_r  <= cfg_wdata[15:0];
        CFG_THR_HIGH: thr_high_r <= cfg_wdata[15:0];
        CFG_EPSILON:  eps_r      <= cfg_wdata[19:0];
        CFG_MIN_DOT:  min_dot_r  <= cfg_wdata[11:0];
        CFG_PITCH:    pitch_r    <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/mdc_div.sv */
// restoring divider, one quotient bit per cycle
module mdc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mdc_pkg::div_req_t         req,
  output logic                      done,
  output logic [mdc_pkg::DIV_QW-1:0] quot
);
  import mdc_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW + 1);

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_QW-1:0] q_r, q_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, q_r[DIV_QW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    fits     = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(DIV_QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in DIV_DW bits
      rem_nxt = fits ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      q_nxt   = {q_r[DIV_QW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* hdl/mdc_checker.sv */
// port-level checks for the metaball dot coverage block, with bind
module mdc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mdc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mdc_pkg::out_item_t out_data
);
  import mdc_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.covered |-> out_data.dot_size == 12'd0 &&
                                       out_data.dot_offset == 12'd0)
    else $error("uncovered item with nonzero size or offset");

  // a load item never creates a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_LOAD && !out_valid |=> !out_valid)
    else $error("result appeared after a load item");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_EVAL |=> !in_ready)
    else $error("ready right after an evaluate item");

endmodule

bind metaball_dot_coverage mdc_checker u_mdc_checker (.*);

/* sim/metaball_dot_coverage_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the metaball dot coverage block

class dot_scoreboard #(int BLOB_COUNT = 5);
  mdc_pkg::blob_t     blobs[BLOB_COUNT];
  logic [15:0]        thr_low;
  logic [15:0]        thr_high;
  logic [19:0]        eps;
  logic [11:0]        min_dot;
  logic [11:0]        pitch;
  mdc_pkg::out_item_t dots_due[$];
  int                 errors;

  function new();
    foreach (blobs[i]) blobs[i] = '0;
    thr_low  = mdc_pkg::THR_LOW_RST;
    thr_high = mdc_pkg::THR_HIGH_RST;
    eps      = mdc_pkg::EPSILON_RST;
    min_dot  = mdc_pkg::MIN_DOT_RST;
    pitch    = mdc_pkg::PITCH_RST;
    errors   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [19:0] val);
    case (idx)
      mdc_pkg::CFG_THR_LOW:  thr_low  = val[15:0];
      mdc_pkg::CFG_THR_HIGH: thr_high = val[15:0];
      mdc_pkg::CFG_EPSILON:  eps      = val;
      mdc_pkg::CFG_MIN_DOT:  min_dot  = val[11:0];
      mdc_pkg::CFG_PITCH:    pitch    = val[11:0];
      default: ;
    endcase
  endfunction

  // saturating sum of r2 / (dist^2 + eps) over the table, Q12.12
  function logic [23:0] field_at(logic signed [15:0] cx, logic signed [15:0] cy);
    logic [63:0] total;
    logic [63:0] dsq;
    logic [63:0] num;
    logic [63:0] term;
    longint      dx;
    longint      dy;
    total = '0;
    foreach (blobs[i]) begin
      dx   = longint'($signed(cx)) - longint'($signed(blobs[i].x));
      dy   = longint'($signed(cy)) - longint'($signed(blobs[i].y));
      dsq  = dx * dx + dy * dy;
      dsq  = dsq + 64'(eps);
      num  = 64'(blobs[i].r2) << 12;
      if (dsq == 0) begin
        term = (num != 0) ? 64'(mdc_pkg::FIELD_MAX) : 64'd0;
      end else begin
        term = num / dsq;
      end
      if (term > 64'(mdc_pkg::FIELD_MAX)) term = 64'(mdc_pkg::FIELD_MAX);
      total = total + term;
      if (total > 64'(mdc_pkg::FIELD_MAX)) total = 64'(mdc_pkg::FIELD_MAX);
    end
    return total[23:0];
  endfunction

  function mdc_pkg::out_item_t dot_for_cell(logic signed [15:0] cx, logic signed [15:0] cy);
    logic [63:0]        field;
    logic [63:0]        cov;
    logic [63:0]        ss;
    logic [63:0]        size;
    mdc_pkg::out_item_t dot;
    dot   = '0;
    field = 64'(field_at(cx, cy));
    if (field <= 64'(thr_low)) return dot;
    if (field >= 64'(thr_high)) begin
      cov = 64'(mdc_pkg::COV_ONE);
    end else begin
      cov = ((field - 64'(thr_low)) << 12) / (64'(thr_high) - 64'(thr_low));
    end
    ss = (cov * cov * (64'(mdc_pkg::SS_K) - 2 * cov)) >> 24;
    if (pitch >= min_dot) begin
      size = 64'(min_dot) + ((ss * (64'(pitch) - 64'(min_dot))) >> 12);
    end else begin
      size = 64'(min_dot) - ((ss * (64'(min_dot) - 64'(pitch))) >> 12);
    end
    dot.covered    = 1'b1;
    dot.dot_size   = size[11:0];
    dot.dot_offset = (size[11:0] > pitch) ? 12'd0 : (pitch - size[11:0]) >> 1;
    return dot;
  endfunction

  function void note_item(mdc_pkg::in_item_t it);
    if (it.op == mdc_pkg::OP_LOAD) begin
      // out of range loads leave the table alone
      if (it.blob_index < BLOB_COUNT) begin
        blobs[it.blob_index] = {it.blob_x, it.blob_y, it.blob_radius_sq};
      end
    end else begin
      dots_due.push_back(dot_for_cell(it.cell_x, it.cell_y));
    end
  endfunction

  function void compare_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_dot(mdc_pkg::out_item_t got);
    mdc_pkg::out_item_t want;
    if (dots_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual covered=%0d size=%0d offset=%0d",
               $time, got.covered, got.dot_size, got.dot_offset);
      return;
    end
    want = dots_due.pop_front();
    compare_field("covered", 12'(want.covered), 12'(got.covered));
    compare_field("dot_size", want.dot_size, got.dot_size);
    compare_field("dot_offset", want.dot_offset, got.dot_offset);
  endfunction

  function int pending();
    return dots_due.size();
  endfunction
endclass

module metaball_dot_coverage_tb;
  import mdc_pkg::*;

  localparam int NUM_BLOBS       = 5;
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int SETTLE_CYCLES   = 260;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  dot_scoreboard #(NUM_BLOBS) sb;
  bit                         calm = 1'b0;
  int                         idle_cycles = 0;

  always #6 clk = ~clk;

  metaball_dot_coverage #(
    .NUM_BLOBS(NUM_BLOBS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] near(int center, int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic in_item_t noise_item();
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t load_item(logic [2:0] idx, logic signed [15:0] x,
                                         logic signed [15:0] y, logic [23:0] r2);
    in_item_t it;
    it                = noise_item();
    it.op             = OP_LOAD;
    it.blob_index     = idx;
    it.blob_x         = x;
    it.blob_y         = y;
    it.blob_radius_sq = r2;
    return it;
  endfunction

  function automatic in_item_t eval_item(logic signed [15:0] cx, logic signed [15:0] cy);
    in_item_t it;
    it        = noise_item();
    it.op     = OP_EVAL;
    it.cell_x = cx;
    it.cell_y = cy;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       k;
    it = noise_item();
    if ($urandom_range(0, 9) < 3) begin
      it.op = OP_LOAD;
      if ($urandom_range(0, 9) == 0) begin
        it.blob_index = 3'($urandom_range(NUM_BLOBS, 7));
      end else begin
        it.blob_index = 3'($urandom_range(0, NUM_BLOBS - 1));
      end
      // cluster half of the blob loads near the origin so cells see overlapping fields
      if ($urandom_range(0, 1) == 1) begin
        it.blob_x = near(0, 12288);
        it.blob_y = near(0, 12288);
      end
      case ($urandom_range(0, 3))
        0: it.blob_radius_sq = 24'($urandom_range(0, 24'h03FFFF));
        1: it.blob_radius_sq = 24'($urandom_range(0, 24'h3FFFFF));
        2: it.blob_radius_sq = ($urandom_range(0, 3) == 0) ? 24'd0 : it.blob_radius_sq;
        default: ;
      endcase
    end else begin
      it.op = OP_EVAL;
      if ($urandom_range(0, 9) < 7) begin
        k         = $urandom_range(0, NUM_BLOBS - 1);
        it.cell_x = near(int'($signed(sb.blobs[k].x)), 6144);
        it.cell_y = near(int'($signed(sb.blobs[k].y)), 6144);
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // loads cause no result, so give the block time to finish before a write
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [19:0] e, input logic [11:0] mn,
                               input logic [11:0] pt);
    cfg_write(CFG_THR_LOW, 20'(lo));
    cfg_write(CFG_THR_HIGH, 20'(hi));
    cfg_write(CFG_EPSILON, e);
    cfg_write(CFG_MIN_DOT, 20'(mn));
    cfg_write(CFG_PITCH, 20'(pt));
    cfg_we <= 1'b0;
  endtask

  task automatic random_registers();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [19:0] e;
    logic [11:0] mn;
    logic [11:0] pt;
    lo = 16'($urandom_range(500, 6000));
    if ($urandom_range(0, 7) == 0) begin
      hi = 16'($urandom_range(0, lo));
    end else begin
      hi = 16'(lo + $urandom_range(1, 6000));
    end
    e  = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 65535));
    pt = 12'($urandom_range(256, 4095));
    mn = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, pt));
    set_registers(lo, hi, e, mn, pt);
  endtask

  // acceptance monitor, result checks and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_dot(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side backpressure
  initial begin
    int gap;
    int hold;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(negedge clk);
    end
  end

  initial begin
    in_item_t it;
    int       phase;
    int       sent;
    int       i;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) settle();
      calm = (phase % 4 == 3);
      case (phase)
        0: begin
          // writes to unused indexes must be ignored
          for (i = int'(CFG_PITCH) + 1; i < (1 << CFG_IDX_W); i++) cfg_write(3'(i), 20'hFFFFF);
          set_registers(THR_LOW_RST, THR_HIGH_RST, EPSILON_RST, MIN_DOT_RST, PITCH_RST);
          send_item(load_item(3'd0, 16'sd0, 16'sd0, 24'h400000));
          send_item(load_item(3'd1, -16'sd32768, -16'sd32768, 24'hFFFFFF));
          send_item(load_item(3'd2, 16'sd32767, 16'sd32767, 24'd0));
          send_item(load_item(3'd3, 16'sh1000, 16'sd0, 24'h100000));
          send_item(load_item(3'd4, -16'sh1000, 16'sh0800, 24'h200000));
          send_item(load_item(3'd5, 16'sd0, 16'sd0, 24'hFFFFFF));
          send_item(load_item(3'd7, 16'sh0800, 16'sh0800, 24'hFFFFFF));
          send_item(eval_item(16'sd0, 16'sd0));
          send_item(eval_item(-16'sd32768, -16'sd32768));
          send_item(eval_item(16'sd32767, 16'sd32767));
          send_item(eval_item(16'sd32767, -16'sd32768));
          send_item(eval_item(16'sh0800, 16'sh0400));
          send_item(eval_item(-16'sd32768, 16'sd32767));
        end
        1: begin
          // zero epsilon: a cell on a loaded blob saturates, on an empty one adds nothing
          set_registers(16'd0, 16'hFFFF, 20'd0, 12'd0, 12'hFFF);
          send_item(eval_item(16'sd0, 16'sd0));
          send_item(eval_item(16'sd32767, 16'sd32767));
          send_item(eval_item(16'sh1000, 16'sd0));
        end
        2: begin
          // high threshold below low, minimum dot above pitch
          set_registers(16'd5000, 16'd1000, 20'hFFFFF, 12'hFFF, 12'd256);
          send_item(eval_item(16'sd0, 16'sh0100));
          send_item(eval_item(16'sh1000, 16'sh0040));
          send_item(eval_item(16'sd0, 16'sh3000));
        end
        3: begin
          // upper data bits beyond the narrow registers are dropped
          cfg_write(CFG_THR_LOW, 20'hFFFFF);
          cfg_write(CFG_THR_HIGH, 20'hFFFFF);
          cfg_write(CFG_EPSILON, 20'd1);
          cfg_write(CFG_MIN_DOT, 20'hFFF00);
          cfg_write(CFG_PITCH, 20'hFF100);
          cfg_we <= 1'b0;
        end
        default: random_registers();
      endcase

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        it = random_item();
        if (!(it.op == OP_LOAD && it.blob_index >= NUM_BLOBS)) sent++;
        send_item(it);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
